/* rtl/cbh_pkg.sv */
`timescale 1ns / 1ps

package cbh_pkg;

    // action codes (s_tuser)
    localparam logic [1:0] ACT_START   = 2'd0;
    localparam logic [1:0] ACT_HEAD    = 2'd1;
    localparam logic [1:0] ACT_PAYLOAD = 2'd2;

    // result status codes (m_tuser)
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;

    // additional-information codes of the head byte
    localparam logic [4:0] AI_IMM_LIMIT = 5'd24;
    localparam logic [4:0] AI_ONE_BYTE  = 5'd24;
    localparam logic [4:0] AI_TWO_BYTE  = 5'd25;
    localparam logic [4:0] AI_FOUR_BYTE = 5'd26;

    localparam logic [15:0] CAP_RESET     = 16'd256;

    // job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // one job: up to five bytes to send (or a single error result)
    typedef struct packed {
        logic [7:0]  head;
        logic [31:0] val;
        logic [2:0]  nbytes;
        logic [1:0]  status;
        logic [15:0] pos;
    } cbh_job_t;

endpackage

/* rtl/cbh_front.sv */
`timescale 1ns / 1ps

module cbh_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_we,
    input  logic [15:0]             cfg_wdata,
    input  logic                    acc,
    input  logic [1:0]              action,
    input  logic [2:0]              major_type,
    input  logic [63:0]             argument_value,
    input  logic [7:0]              payload_byte,
    output logic                    push,
    output cbh_pkg::cbh_job_t       job
);

    logic [15:0] cap_reg, cap_next;
    logic [15:0] off_reg, off_next;
    logic        failed_reg, failed_next;

    logic        is_small, le8, le16, le32;
    logic [2:0]  nb;
    logic [7:0]  head;
    logic [16:0] end_off;
    logic        fits;

    // size class of the argument
    assign is_small = (argument_value < 64'(cbh_pkg::AI_IMM_LIMIT));
    assign le8      = (argument_value[63:8] == '0);
    assign le16     = (argument_value[63:16] == '0);
    assign le32     = (argument_value[63:32] == '0);

    always_comb begin
        if (action == cbh_pkg::ACT_PAYLOAD) begin
            nb   = 3'd1;
            head = payload_byte;
        end else if (is_small) begin
            nb   = 3'd1;
            head = {major_type, argument_value[4:0]};
        end else if (le8) begin
            nb   = 3'd2;
            head = {major_type, cbh_pkg::AI_ONE_BYTE};
        end else if (le16) begin
            nb   = 3'd3;
            head = {major_type, cbh_pkg::AI_TWO_BYTE};
        end else begin
            nb   = 3'd5;
            head = {major_type, cbh_pkg::AI_FOUR_BYTE};
        end
    end

    assign end_off = {1'b0, off_reg} + {14'd0, nb};
    assign fits    = (end_off <= {1'b0, cap_reg});

    always_comb begin
        off_next    = off_reg;
        failed_next = failed_reg;
        cap_next    = cfg_we ? cfg_wdata : cap_reg;
        push        = 1'b0;
        job.head    = 8'd0;
        job.val     = 32'd0;
        job.nbytes  = 3'd1;
        job.status  = cbh_pkg::ST_OK;
        job.pos     = off_reg;
        if (acc) begin
            case (action)
                cbh_pkg::ACT_START: begin
                    off_next    = '0;
                    failed_next = 1'b0;
                end
                cbh_pkg::ACT_HEAD, cbh_pkg::ACT_PAYLOAD: begin
                    push = 1'b1;
                    if (failed_reg) begin
                        job.status = cbh_pkg::ST_OVERFLOW;
                    end else if (action == cbh_pkg::ACT_HEAD && !le32) begin
                        job.status  = cbh_pkg::ST_TOO_LARGE;
                        failed_next = 1'b1;
                    end else if (!fits) begin
                        job.status  = cbh_pkg::ST_OVERFLOW;
                        failed_next = 1'b1;
                    end else begin
                        job.head   = head;
                        job.val    = argument_value[31:0];
                        job.nbytes = nb;
                        off_next   = end_off[15:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= cbh_pkg::CAP_RESET;
            off_reg    <= '0;
            failed_reg <= 1'b0;
        end else begin
            cap_reg    <= cap_next;
            off_reg    <= off_next;
            failed_reg <= failed_next;
        end
    end

    // offset only moves on an accepted item
    a_off_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !acc |=> $stable(off_reg))
        else $error("write offset moved without a transfer");

    // a failed message never advances the offset
    a_failed_no_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        (failed_reg && acc && action != cbh_pkg::ACT_START) |=> $stable(off_reg))
        else $error("offset advanced on a failed message");

endmodule

/* rtl/cbh_queue.sv */
`timescale 1ns / 1ps

module cbh_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  cbh_pkg::cbh_job_t       push_job,
    output logic                    full,
    input  logic                    pop,
    output cbh_pkg::cbh_job_t       pop_job,
    output logic                    empty
);

    cbh_pkg::cbh_job_t            mem [cbh_pkg::QDEPTH];
    logic [cbh_pkg::QAW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [cbh_pkg::QAW:0]        cnt_reg, cnt_next;

    assign full    = (cnt_reg == (cbh_pkg::QAW+1)'(cbh_pkg::QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_job = mem[rd_ptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full) && !(pop && empty))
        else $error("job queue overrun or underrun");

endmodule

/* rtl/cbh_back.sv */
`timescale 1ns / 1ps

module cbh_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_empty,
    input  cbh_pkg::cbh_job_t       q_job,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [23:0]             m_tdata,
    output logic [1:0]              m_tuser,
    output logic                    m_tlast
);

    cbh_pkg::cbh_job_t cur_reg;
    logic              cur_valid_reg, cur_valid_next;
    logic [2:0]        idx_reg, idx_next;

    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic [15:0]       out_pos_reg;
    logic [1:0]        out_status_reg;
    logic              out_last_reg;

    logic              load_out, emit, is_last;
    logic [2:0]        k;
    logic [7:0]        sel_byte;

    assign load_out = !out_valid_reg || m_tready;
    assign emit     = load_out && cur_valid_reg;
    assign is_last  = (idx_reg == cur_reg.nbytes - 3'd1);
    assign pop      = !q_empty && (!cur_valid_reg || (emit && is_last));

    // big-endian: byte index counted from the end of the argument
    assign k = cur_reg.nbytes - 3'd1 - idx_reg;

    always_comb begin
        if (idx_reg == 3'd0) begin
            sel_byte = cur_reg.head;
        end else begin
            case (k)
                3'd0:    sel_byte = cur_reg.val[7:0];
                3'd1:    sel_byte = cur_reg.val[15:8];
                3'd2:    sel_byte = cur_reg.val[23:16];
                3'd3:    sel_byte = cur_reg.val[31:24];
                default: sel_byte = 8'd0;
            endcase
        end
    end

    always_comb begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop) begin
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end else if (emit) begin
            if (is_last) begin
                cur_valid_next = 1'b0;
                idx_next       = '0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= q_job;
        end
        if (emit) begin
            out_byte_reg   <= sel_byte;
            out_pos_reg    <= cur_reg.pos + {13'd0, idx_reg};
            out_status_reg <= cur_reg.status;
            out_last_reg   <= is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            if (load_out) begin
                out_valid_reg <= cur_valid_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pos_reg, out_byte_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_valid_reg |-> (idx_reg < cur_reg.nbytes))
        else $error("byte index past end of job");

    a_err_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg != cbh_pkg::ST_OK)
            |-> (out_last_reg && out_byte_reg == 8'd0))
        else $error("error result not a single zero byte");

    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) ##1 m_tvalid
            |-> (out_pos_reg == $past(out_pos_reg) + 16'd1))
        else $error("byte position did not advance within an item");

endmodule

/* rtl/cbor_item_head_encoder.sv */
`timescale 1ns / 1ps

// CBOR item head encoder. Each input transfer carries an action in s_tuser:
// start (resets offset and error, no output), head (major type plus argument,
// encoded as 1, 2, 3 or 5 big-endian bytes) or payload (one raw byte). Each
// output transfer is one byte with its offset in the message; m_tlast marks
// the final byte of an item and m_tuser gives the status (0 ok, 1 overflow or
// message already failed, 2 argument wider than 32 bits). An error item gives
// a single transfer with a zero byte and the refusing offset. Errors stick
// until the next start. The capacity register (reset 256) is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, as the
// block itself does not enforce this. Rate: the input side takes one transfer
// per cycle while the four-entry job queue has room; the output side sends one
// byte per cycle while m_tready is high, so an item of n bytes (1 to 5) gives n
// output transfers, and start or unused actions give none.

module cbor_item_head_encoder (
    input  logic        aclk,
    input  logic        aresetn,

    // capacity register write
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // [2:0] major_type, [66:3] argument_value,
                                   // [74:67] payload_byte, [79:75] zero
    input  logic [1:0]  s_tuser,   // [1:0] action

    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] byte_position
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast    // last_of_item
);

    cbh_pkg::cbh_job_t push_job, pop_job;
    logic              push, pop, q_full, q_empty;
    logic              s_acc;

    // front accepts whenever a queue slot is free
    assign s_tready = !q_full;
    assign s_acc    = s_tvalid && s_tready;

    cbh_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .acc            (s_acc),
        .action         (s_tuser),
        .major_type     (s_tdata[2:0]),
        .argument_value (s_tdata[66:3]),
        .payload_byte   (s_tdata[74:67]),
        .push           (push),
        .job            (push_job)
    );

    cbh_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    // back end serializes one job at a time into the output register
    cbh_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_job    (pop_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    // local names for the package codes
    localparam logic [1:0]  ACT_START    = cbh_pkg::ACT_START;
    localparam logic [1:0]  ACT_HEAD     = cbh_pkg::ACT_HEAD;
    localparam logic [1:0]  ACT_PAYLOAD  = cbh_pkg::ACT_PAYLOAD;
    localparam logic [1:0]  ST_OK        = cbh_pkg::ST_OK;
    localparam logic [1:0]  ST_OVERFLOW  = cbh_pkg::ST_OVERFLOW;
    localparam logic [1:0]  ST_TOO_LARGE = cbh_pkg::ST_TOO_LARGE;
    localparam logic [4:0]  AI_IMM_LIMIT = cbh_pkg::AI_IMM_LIMIT;
    localparam logic [4:0]  AI_ONE_BYTE  = cbh_pkg::AI_ONE_BYTE;
    localparam logic [4:0]  AI_TWO_BYTE  = cbh_pkg::AI_TWO_BYTE;
    localparam logic [4:0]  AI_FOUR_BYTE = cbh_pkg::AI_FOUR_BYTE;
    localparam logic [15:0] CAP_RESET    = cbh_pkg::CAP_RESET;

    // action code 3 is not defined by the package: the block must drop it silently
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    // cycles to wait after the last expected transfer, covering start and unused
    // actions still inside the pipeline
    localparam int SETTLE_CYCLES = 16;
    // number of items in each random phase
    localparam int PHASE_ITEMS = 36;

    // one output byte as seen on the m_ side
    typedef struct packed {
        logic [7:0]  data;
        logic [1:0]  status;
        logic [15:0] pos;
        logic        last;
    } enc_byte_t;

    // directed plan: one item, or one capacity write carried in arg[15:0]
    typedef enum logic { ROW_ITEM, ROW_CAP } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  act;
        logic [2:0]  mt;
        logic [63:0] arg;
        logic [7:0]  pb;
        logic        typed;      // expected transfer given below, single result only
        logic [7:0]  t_byte;
        logic [1:0]  t_status;
        logic [15:0] t_pos;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;     // [2:0] major_type, [66:3] argument_value,
                              // [74:67] payload_byte, [79:75] zero
    logic [1:0]  s_tuser;     // [1:0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;     // [7:0] out_byte, [23:8] byte_position
    logic [1:0]  m_tuser;     // [1:0] status
    logic        m_tlast;     // last_of_item

    // predictor state, mirrors the block's registers
    logic [15:0] capacity_model;
    logic [15:0] msg_offset;
    logic        msg_failed;

    enc_byte_t   expected_bytes [$];
    int          error_count = 0;
    int          items_sent = 0;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    row_t plan [32];

    cbor_item_head_encoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Expected bytes of one item; updates offset and failure state.
    // Returns the number of transfers the item causes (0 to 5).
    function automatic int encode_item(input logic [1:0] act, input logic [2:0] mt,
                                       input logic [63:0] arg, input logic [7:0] pb,
                                       output enc_byte_t res [5]);
        logic [7:0] head_bytes [5];
        int         n;

        for (int i = 0; i < 5; i++) begin
            res[i] = '0;
            head_bytes[i] = 8'd0;
        end
        if (act == ACT_START) begin
            msg_offset = 16'd0;
            msg_failed = 1'b0;
            return 0;
        end
        if (act == ACT_UNUSED)
            return 0;
        // a failed message refuses everything until the next start, state untouched
        if (msg_failed) begin
            res[0] = '{8'd0, ST_OVERFLOW, msg_offset, 1'b1};
            return 1;
        end

        if (act == ACT_PAYLOAD) begin
            n = 1;
            head_bytes[0] = pb;
        end else if (arg < 64'(AI_IMM_LIMIT)) begin
            n = 1;
            head_bytes[0] = {mt, arg[4:0]};
        end else if (arg <= 64'hFF) begin
            n = 2;
            head_bytes[0] = {mt, AI_ONE_BYTE};
            head_bytes[1] = arg[7:0];
        end else if (arg <= 64'hFFFF) begin
            n = 3;
            head_bytes[0] = {mt, AI_TWO_BYTE};
            head_bytes[1] = arg[15:8];
            head_bytes[2] = arg[7:0];
        end else if (arg <= 64'hFFFF_FFFF) begin
            n = 5;
            head_bytes[0] = {mt, AI_FOUR_BYTE};
            head_bytes[1] = arg[31:24];
            head_bytes[2] = arg[23:16];
            head_bytes[3] = arg[15:8];
            head_bytes[4] = arg[7:0];
        end else begin
            msg_failed = 1'b1;
            res[0] = '{8'd0, ST_TOO_LARGE, msg_offset, 1'b1};
            return 1;
        end

        // the whole head must fit; a capacity below the offset refuses too
        if (32'(msg_offset) + 32'(n) > 32'(capacity_model)) begin
            msg_failed = 1'b1;
            res[0] = '{8'd0, ST_OVERFLOW, msg_offset, 1'b1};
            return 1;
        end
        for (int i = 0; i < n; i++)
            res[i] = '{head_bytes[i], ST_OK, msg_offset + 16'(i), i == n - 1};
        msg_offset = msg_offset + 16'(n);
        return n;
    endfunction

    // argument sizes spread over every head form, with the boundaries
    function automatic logic [63:0] pick_argument();
        case ($urandom_range(9))
            0, 1, 2: return 64'($urandom_range(23));
            3, 4:    return 64'($urandom_range(255, 24));
            5, 6:    return 64'($urandom_range(65535, 256));
            7:       return 64'($urandom_range(32'hFFFF_FFFF, 32'h1_0000));
            8: begin
                case ($urandom_range(5))
                    0:       return 64'd23;
                    1:       return 64'd255;
                    2:       return 64'd256;
                    3:       return 64'h1_0000;
                    4:       return 64'hFFFF_FFFF;
                    default: return 64'h1_0000_0000;
                endcase
            end
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic report_mismatch(input string what, input enc_byte_t got,
                                   input enc_byte_t want);
        $display({"[%0t] %s: got byte %02h st %0d pos %0d last %0b, ",
                  "want byte %02h st %0d pos %0d last %0b"},
                 $time, what, got.data, got.status, got.pos, got.last,
                 want.data, want.status, want.pos, want.last);
        error_count++;
    endtask

    // Drive one item, hold it until the transfer, then log what it should cause.
    // Called at a clock edge; returns at the edge of the transfer with s_tvalid high.
    task automatic send_item(input logic [1:0] act, input logic [2:0] mt,
                             input logic [63:0] arg, input logic [7:0] pb,
                             input logic typed = 1'b0, input enc_byte_t typed_res = '0);
        enc_byte_t res [5];
        int        n;

        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, pb, arg, mt};
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);

        n = encode_item(act, mt, arg, pb, res);
        if (typed)
            expected_bytes.push_back(typed_res);
        else
            for (int i = 0; i < n; i++)
                expected_bytes.push_back(res[i]);
        if (act != ACT_UNUSED)
            items_sent++;
    endtask

    // stop sending, let every expected transfer arrive, then let the pipeline empty
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [15:0] cap);
        drain_and_settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        capacity_model = cap;
    endtask

    // one message: mostly well-formed heads, strings and containers, some noise
    task automatic send_random_message();
        int elems;
        int len;
        int pick;

        // now and then no start, so a message runs on (or stays failed)
        if ($urandom_range(9) != 0)
            send_item(ACT_START, 3'($urandom), {$urandom, $urandom}, 8'($urandom));
        elems = $urandom_range(6, 1);
        repeat (elems) begin
            pick = $urandom_range(19);
            if (pick < 8) begin
                send_item(ACT_HEAD, 3'($urandom_range(7)), pick_argument(), 8'($urandom));
            end else if (pick < 13) begin
                // byte or text string: length head, then the raw bytes
                len = $urandom_range(6);
                send_item(ACT_HEAD, pick[0] ? 3'd3 : 3'd2, 64'(len), 8'($urandom));
                repeat (len)
                    send_item(ACT_PAYLOAD, 3'($urandom), {$urandom, $urandom},
                              8'($urandom));
            end else if (pick < 17) begin
                // array or map head with up to three integer members
                len = $urandom_range(3);
                send_item(ACT_HEAD, pick[0] ? 3'd4 : 3'd5, 64'(len), 8'($urandom));
                repeat (len)
                    send_item(ACT_HEAD, 3'($urandom_range(1)), pick_argument(),
                              8'($urandom));
            end else begin
                // anything, unused action code included
                send_item(2'($urandom), 3'($urandom), {$urandom, $urandom}, 8'($urandom));
            end
        end
    endtask

    // receiver stalls at random; sampled with the pre-edge values
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // each transfer is checked against the oldest expectation
    always @(posedge aclk) begin
        enc_byte_t got;
        enc_byte_t want;

        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[7:0], m_tuser, m_tdata[23:8], m_tlast};
            if (expected_bytes.size() == 0) begin
                report_mismatch("transfer with nothing expected", got, '0);
            end else begin
                want = expected_bytes.pop_front();
                if (got !== want)
                    report_mismatch("transfer mismatch", got, want);
            end
        end
    end

    initial begin
        int          r;
        int          phase;
        int          quota;
        logic [15:0] cap;

        // directed plan; typed rows are read straight off the encoding rules
        plan = '{
            // capacity 256 after reset: every head form, both major-type extremes
            '{ROW_ITEM, ACT_HEAD,    3'd0, 64'd0,         8'h00, 1'b1, 8'h00, ST_OK,        16'd0},
            '{ROW_ITEM, ACT_HEAD,    3'd7, 64'd23,        8'h00, 1'b1, 8'hF7, ST_OK,        16'd1},
            '{ROW_ITEM, ACT_HEAD,    3'd1, 64'd24,        8'h00, 1'b0, 8'h00, ST_OK,        16'd0},
            '{ROW_ITEM, ACT_HEAD,    3'd2, 64'd255,       8'h00, 1'b0, 8'h00, ST_OK,        16'd0},
            '{ROW_ITEM, ACT_HEAD,    3'd3, 64'd256,       8'h00, 1'b0, 8'h00, ST_OK,        16'd0},
            '{ROW_ITEM, ACT_HEAD,    3'd4, 64'hFFFF,      8'h00, 1'b0, 8'h00, ST_OK,        16'd0},
            '{ROW_ITEM, ACT_HEAD,    3'd5, 64'h1_0000,    8'h00, 1'b0, 8'h00, ST_OK,        16'd0},
            '{ROW_ITEM, ACT_HEAD,    3'd6, 64'hFFFF_FFFF, 8'h00, 1'b0, 8'h00, ST_OK,        16'd0},
            '{ROW_ITEM, ACT_PAYLOAD, 3'd0, 64'd0,         8'h00, 1'b1, 8'h00, ST_OK,        16'd22},
            '{ROW_ITEM, ACT_PAYLOAD, 3'd7, '1,            8'hFF, 1'b1, 8'hFF, ST_OK,        16'd23},
            // unused action: no transfer, no state change
            '{ROW_ITEM, ACT_UNUSED,  3'd7, '1,            8'hFF, 1'b0, 8'h00, ST_OK,        16'd0},
            // just over 32 bits, then a payload while failed
            '{ROW_ITEM, ACT_HEAD,    3'd0, 64'h100000000, 8'h00, 1'b1, 8'h00, ST_TOO_LARGE, 16'd24},
            '{ROW_ITEM, ACT_PAYLOAD, 3'd0, 64'd0,         8'h5A, 1'b1, 8'h00, ST_OVERFLOW,  16'd24},
            '{ROW_ITEM, ACT_START,   3'd0, 64'd0,         8'h00, 1'b0, 8'h00, ST_OK,        16'd0},
            '{ROW_ITEM, ACT_HEAD,    3'd7, '1,            8'h00, 1'b1, 8'h00, ST_TOO_LARGE, 16'd0},
            '{ROW_ITEM, ACT_START,   3'd0, 64'd0,         8'h00, 1'b0, 8'h00, ST_OK,        16'd0},
            // capacity 1: one payload fits, the next does not
            '{ROW_CAP,  ACT_START,   3'd0, 64'd1,         8'h00, 1'b0, 8'h00, ST_OK,        16'd0},
            '{ROW_ITEM, ACT_PAYLOAD, 3'd0, 64'd0,         8'hA5, 1'b1, 8'hA5, ST_OK,        16'd0},
            '{ROW_ITEM, ACT_PAYLOAD, 3'd0, 64'd0,         8'h3C, 1'b1, 8'h00, ST_OVERFLOW,  16'd1},
            '{ROW_ITEM, ACT_START,   3'd0, 64'd0,         8'h00, 1'b0, 8'h00, ST_OK,        16'd0},
            // a two-byte head never fits in one byte
            '{ROW_ITEM, ACT_HEAD,    3'd2, 64'd24,        8'h00, 1'b1, 8'h00, ST_OVERFLOW,  16'd0},
            '{ROW_ITEM, ACT_START,   3'd0, 64'd0,         8'h00, 1'b0, 8'h00, ST_OK,        16'd0},
            // capacity zero refuses everything
            '{ROW_CAP,  ACT_START,   3'd0, 64'd0,         8'h00, 1'b0, 8'h00, ST_OK,        16'd0},
            '{ROW_ITEM, ACT_PAYLOAD, 3'd0, 64'd0,         8'h11, 1'b1, 8'h00, ST_OVERFLOW,  16'd0},
            '{ROW_ITEM, ACT_START,   3'd0, 64'd0,         8'h00, 1'b0, 8'h00, ST_OK,        16'd0},
            // exact fit of a five-byte head, then capacity lowered below the offset
            '{ROW_CAP,  ACT_START,   3'd0, 64'd5,         8'h00, 1'b0, 8'h00, ST_OK,        16'd0},
            '{ROW_ITEM, ACT_HEAD,    3'd6, 64'hDEAD_BEEF, 8'h00, 1'b0, 8'h00, ST_OK,        16'd0},
            '{ROW_CAP,  ACT_START,   3'd0, 64'd3,         8'h00, 1'b0, 8'h00, ST_OK,        16'd0},
            '{ROW_ITEM, ACT_HEAD,    3'd0, 64'd0,         8'h00, 1'b1, 8'h00, ST_OVERFLOW,  16'd5},
            '{ROW_ITEM, ACT_START,   3'd0, 64'd0,         8'h00, 1'b0, 8'h00, ST_OK,        16'd0},
            // largest capacity
            '{ROW_CAP,  ACT_START,   3'd0, 64'hFFFF,      8'h00, 1'b0, 8'h00, ST_OK,        16'd0},
            '{ROW_ITEM, ACT_HEAD,    3'd7, 64'h7FFF_FFFF, 8'h00, 1'b0, 8'h00, ST_OK,        16'd0}
        };

        // every input known from time zero
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 16'd0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = ACT_START;
        capacity_model = CAP_RESET;
        msg_offset     = 16'd0;
        msg_failed     = 1'b0;
        send_idle_pct  = 20;
        recv_idle_pct  = 65;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part
        for (r = 0; r < $size(plan); r++) begin
            if (plan[r].kind == ROW_CAP)
                write_capacity(plan[r].arg[15:0]);
            else
                send_item(plan[r].act, plan[r].mt, plan[r].arg, plan[r].pb, plan[r].typed,
                          '{plan[r].t_byte, plan[r].t_status, plan[r].t_pos, 1'b1});
        end

        // random part: receiver-heavy idling, then sender-heavy, then none;
        // each phase under a new capacity, small ones to hit overflow often
        for (phase = 0; phase < 6; phase++) begin
            send_idle_pct = (phase < 2) ? 20 : (phase < 4) ? 65 : 0;
            recv_idle_pct = (phase < 2) ? 65 : (phase < 4) ? 20 : 0;
            case (phase)
                0:       cap = 16'd1;
                1:       cap = 16'hFFFF;
                2:       cap = 16'($urandom_range(40, 6));
                3:       cap = 16'($urandom_range(65535, 1));
                4:       cap = 16'($urandom_range(24, 8));
                default: cap = CAP_RESET;
            endcase
            write_capacity(cap);
            quota = items_sent + PHASE_ITEMS;
            while (items_sent < quota)
                send_random_message();
        end

        drain_and_settle();
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // hang guard: far above the slowest legal run
    initial begin
        #2_000_000;
        $display("testbench: done, errors");
        $finish;
    end

endmodule

/* sim.f */
rtl/cbh_pkg.sv
rtl/cbh_front.sv
rtl/cbh_queue.sv
rtl/cbh_back.sv
rtl/cbor_item_head_encoder.sv
test/testbench.sv
